### design/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### design/hctlp_pkg.sv
package hctlp_pkg;
  localparam logic [2:0] ST_INSERTED    = 3'd0;
  localparam logic [2:0] ST_INCREMENTED = 3'd1;
  localparam logic [2:0] ST_FOUND       = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [2:0] ST_FULL        = 3'd4;
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;
  localparam int SHIFT_LEFT  = 23;
  localparam int SHIFT_RIGHT = 17;
  localparam int FOLD        = 32;

  typedef struct packed {
    logic [31:0] reg_id;
    logic [15:0] key_kind;
    logic [4:0]  key_bytes;
    logic [63:0] value_low;
    logic [63:0] value_high;
  } key_t;
endpackage

### design/hctlp_hash.sv
module hctlp_hash #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hctlp_pkg::key_t   key,
  output logic              done,
  output logic [31:0]       hash
);
  logic [63:0] h;
  logic [4:0]  step;
  logic [4:0]  len;
  logic        busy;
  logic [63:0] mixed;
  logic [63:0] fold_in;
  logic [3:0]  bidx;
  logic [63:0] word;
  hctlp_pkg::key_t k;

  assign mixed = h ^ (h << hctlp_pkg::SHIFT_LEFT) ^ (h >> hctlp_pkg::SHIFT_RIGHT);
  assign bidx  = 4'(step - 5'd2);
  assign word  = bidx[3] ? k.value_high : k.value_low;
  assign fold_in = (step == 5'd0) ? {48'd0, k.key_kind} :
                   (step == 5'd1) ? {59'd0, len} :
                   {56'd0, word[{bidx[2:0], 3'b000} +: 8]};
  assign hash = h[31:0] ^ h[63:hctlp_pkg::FOLD];

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 5'd0;
      k    <= key;
      len  <= (key.key_bytes > 5'(MAX_KEY_BYTES)) ? 5'(MAX_KEY_BYTES) : key.key_bytes;
      h    <= {32'd0, key.reg_id};
    end else if (busy) begin
      if (step == len + 5'd2) begin
        h    <= mixed;
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        h    <= mixed ^ fold_in;
        step <= step + 5'd1;
      end
    end
  end
endmodule

### design/hash_count_table_linear_probe.sv
// Occurrence-counting hash table with linear probing.
// Input channel s_*: one word per operation, accepted on s_tvalid & s_tready.
//   tuser holds op (0 insert/add, 1 lookup).
// Output channel m_*: one result word per input word, held until m_tready.
// Each item runs through the hash, then the slot reduction (multiply,
// subtract, then compare and subtract until below the depth), then a table
// read and a compare/write (S_RD, S_CMP) per probed slot, before m_tvalid
// rises. Up to TABLE_DEPTH slots are probed when the table is nearly full.
// s_tready is low while an item is in flight or a result waits, so only one
// item is at work at a time; a stalled receiver simply holds the block.
// Reset (rst, synchronous) runs a clearing pass over all TABLE_DEPTH valid
// bits and zeroes the occupancy count; s_tready stays low meanwhile.
// Keys longer than MAX_KEY_BYTES are cut to that length; bytes past the
// length are ignored. Counts saturate at all ones.
module hash_count_table_linear_probe #(
  parameter int TABLE_DEPTH   = 1024,
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // reg_id[31:0], key_kind[47:32], key_bytes[52:48], value_low[116:53],
  // value_high[180:117], initial_count[212:181], zero fill
  input  logic [215:0]  s_tdata,
  // op
  input  logic          s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // status[2:0], hit_count[34:3], slot[44:35], occupancy[55:45]
  output logic [55:0]   m_tdata
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);
  localparam logic [31:0] RECIP   = 32'(64'hFFFF_FFFF / 64'(TABLE_DEPTH));
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_HASH = 4'd2,
    S_RD = 4'd3, S_CMP = 4'd4, S_OUT = 4'd5, S_MUL = 4'd6, S_MOD = 4'd7;

  typedef struct packed {
    logic [31:0] hash;
    hctlp_pkg::key_t key;
    logic [31:0] count;
  } entry_t;

  logic [3:0] state;
  logic [AW-1:0] clr_idx, idx, home;
  logic [CW-1:0] used, probes;
  logic op;
  hctlp_pkg::key_t key, key_in;
  logic [31:0] init, hash, count_q;
  logic hash_start, hash_done;
  logic vmem [TABLE_DEPTH];
  entry_t emem [TABLE_DEPTH];
  entry_t rd;
  logic rd_v;
  logic [2:0] status;
  logic [63:0] lo_mask, hi_mask;
  logic [4:0] len;
  logic [63:0] prod;
  logic [31:0] quo, qd, rem;

  assign len = (s_tdata[52:48] > 5'(MAX_KEY_BYTES)) ? 5'(MAX_KEY_BYTES) : s_tdata[52:48];
  assign lo_mask = (len >= 5'd8) ? '1 : ((64'd1 << {len[2:0], 3'b000}) - 64'd1);
  assign hi_mask = (len >= 5'd16) ? '1 : (len <= 5'd8) ? 64'd0 :
                   ((64'd1 << {len[2:0], 3'b000}) - 64'd1);
  assign key_in.reg_id      = s_tdata[31:0];
  assign key_in.key_kind    = s_tdata[47:32];
  assign key_in.key_bytes   = len;
  assign key_in.value_low   = s_tdata[116:53] & lo_mask;
  assign key_in.value_high  = s_tdata[180:117] & hi_mask;

  assign s_tready = (state == S_IDLE);
  assign hash_start = s_tvalid && s_tready;
  // quotient estimate never exceeds the true one and is off by at most 3
  assign prod = {32'd0, hash} * {32'd0, RECIP};
  assign qd = quo * DEPTH_W;

  hctlp_hash #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_hash (
    .clk(clk), .rst(rst), .start(hash_start), .key(key_in),
    .done(hash_done), .hash(hash)
  );

  always_ff @(posedge clk) begin
    if (state == S_CLR) vmem[clr_idx] <= 1'b0;
    else if (state == S_CMP && op == hctlp_pkg::OP_INSERT && !rd_v)
      vmem[idx] <= 1'b1;
    rd_v <= vmem[idx];
  end

  always_ff @(posedge clk) begin
    if (state == S_CMP && op == hctlp_pkg::OP_INSERT) begin
      if (!rd_v) emem[idx] <= '{hash: hash, key: key, count: init};
      else if (rd.hash == hash && rd.key == key && rd.count != '1)
        emem[idx] <= '{hash: rd.hash, key: rd.key, count: rd.count + 32'd1};
    end
    rd <= emem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_idx <= '0;
      used <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(TABLE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (hash_start) begin
          key <= key_in;
          op <= s_tuser;
          init <= s_tdata[212:181];
          state <= S_HASH;
        end
        S_HASH: if (hash_done) begin
          quo <= prod[63:32];
          state <= S_MUL;
        end
        S_MUL: begin
          rem <= hash - qd;
          state <= S_MOD;
        end
        S_MOD: begin
          if (rem >= DEPTH_W) begin
            rem <= rem - DEPTH_W;
          end else begin
            home <= AW'(rem);
            idx <= AW'(rem);
            probes <= '0;
            state <= S_RD;
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (!rd_v) begin
            if (op == hctlp_pkg::OP_INSERT) begin
              status <= hctlp_pkg::ST_INSERTED;
              count_q <= init;
              used <= used + 1'b1;
            end else begin
              status <= hctlp_pkg::ST_NOT_FOUND;
              count_q <= '0;
            end
            state <= S_OUT;
          end else if (rd.hash == hash && rd.key == key) begin
            status <= (op == hctlp_pkg::OP_INSERT) ? hctlp_pkg::ST_INCREMENTED
                                                   : hctlp_pkg::ST_FOUND;
            count_q <= (op == hctlp_pkg::OP_INSERT && rd.count != '1)
                       ? rd.count + 32'd1 : rd.count;
            state <= S_OUT;
          end else if (probes == CW'(TABLE_DEPTH - 1)) begin
            status <= (op == hctlp_pkg::OP_INSERT) ? hctlp_pkg::ST_FULL
                                                   : hctlp_pkg::ST_NOT_FOUND;
            count_q <= '0;
            idx <= home;
            state <= S_OUT;
          end else begin
            probes <= probes + 1'b1;
            idx <= (idx == AW'(TABLE_DEPTH - 1)) ? '0 : idx + 1'b1;
            state <= S_RD;
          end
        end
        S_OUT: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata <= {11'(used), 10'(idx), count_q, status};
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### design/hctlp_checker.sv
`include "assert_macros.svh"
module hctlp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [55:0]  m_tdata
);
  `ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ASSERT_IMPL(a_excl, clk, rst, m_tvalid, !s_tready)
  `ASSERT_IMPL(a_status, clk, rst, m_tvalid, m_tdata[2:0] <= hctlp_pkg::ST_FULL)
  `ASSERT_IMPL(a_zero, clk, rst, m_tvalid && (m_tdata[2:0] == hctlp_pkg::ST_NOT_FOUND || m_tdata[2:0] == hctlp_pkg::ST_FULL), m_tdata[34:3] == 32'd0)
  `ASSERT_NEXT(a_busy, clk, rst, s_tvalid && s_tready, !s_tready)
endmodule

bind hash_count_table_linear_probe hctlp_checker u_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  localparam int DEPTH      = 1024;
  localparam int MAX_BYTES  = 16;
  localparam int POOL       = 300;
  localparam int RAND_ITEMS = 250;
  localparam int LIMIT      = 10000000;

  typedef struct packed {
    logic [10:0] occupancy;
    logic [9:0]  slot;
    logic [31:0] hit_count;
    logic [2:0]  status;
  } reply_t;

  typedef struct packed {
    logic            op;
    hctlp_pkg::key_t key;
    logic [31:0]     init;
    logic            typed;
    logic [2:0]      status;
    logic [31:0]     hit_count;
  } row_t;

  localparam row_t ROWS [14] = '{
    '{hctlp_pkg::OP_LOOKUP, '{32'd0, 16'd0, 5'd0, 64'd0, 64'd0}, 32'd0, 1'b1,
      hctlp_pkg::ST_NOT_FOUND, 32'd0},
    '{hctlp_pkg::OP_INSERT, '{32'd0, 16'd0, 5'd0, 64'd0, 64'd0}, 32'd0, 1'b1,
      hctlp_pkg::ST_INSERTED, 32'd0},
    '{hctlp_pkg::OP_INSERT, '{32'd0, 16'd0, 5'd0, 64'd0, 64'd0}, 32'd9, 1'b1,
      hctlp_pkg::ST_INCREMENTED, 32'd1},
    '{hctlp_pkg::OP_LOOKUP, '{32'd0, 16'd0, 5'd0, '1, '1}, 32'd0, 1'b1,
      hctlp_pkg::ST_FOUND, 32'd1},
    '{hctlp_pkg::OP_INSERT, '{'1, '1, 5'd16, '1, '1}, '1, 1'b1,
      hctlp_pkg::ST_INSERTED, '1},
    '{hctlp_pkg::OP_INSERT, '{'1, '1, 5'd16, '1, '1}, 32'd0, 1'b1,
      hctlp_pkg::ST_INCREMENTED, '1},
    '{hctlp_pkg::OP_LOOKUP, '{'1, '1, 5'd16, '1, '1}, 32'd0, 1'b1,
      hctlp_pkg::ST_FOUND, '1},
    '{hctlp_pkg::OP_INSERT, '{32'd0, 16'd0, 5'd31, '1, '1}, 32'd5, 1'b1,
      hctlp_pkg::ST_INSERTED, 32'd5},
    '{hctlp_pkg::OP_LOOKUP, '{32'd0, 16'd0, 5'd16, '1, '1}, 32'd0, 1'b1,
      hctlp_pkg::ST_FOUND, 32'd5},
    '{hctlp_pkg::OP_INSERT, '{32'h1234, 16'h55, 5'd3, 64'h123456, 64'd0}, 32'd7, 1'b1,
      hctlp_pkg::ST_INSERTED, 32'd7},
    '{hctlp_pkg::OP_LOOKUP, '{32'h1234, 16'h55, 5'd3, 64'hffff_ffff_ff12_3456, '1}, 32'd0,
      1'b1, hctlp_pkg::ST_FOUND, 32'd7},
    '{hctlp_pkg::OP_LOOKUP, '{32'h1234, 16'h56, 5'd3, 64'h123456, 64'd0}, 32'd0, 1'b1,
      hctlp_pkg::ST_NOT_FOUND, 32'd0},
    '{hctlp_pkg::OP_INSERT, '{'1, 16'd0, 5'd8, 64'd0, '1}, 32'd1, 1'b1,
      hctlp_pkg::ST_INSERTED, 32'd1},
    '{hctlp_pkg::OP_INSERT,
      '{32'h8000_0000, 16'h8000, 5'd9, 64'h8000_0000_0000_0001, 64'h80},
      32'h8000_0000, 1'b0, hctlp_pkg::ST_INSERTED, 32'd0}
  };

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [215:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [55:0]  m_tdata;

  logic            tbl_valid [DEPTH];
  logic [31:0]     tbl_hash  [DEPTH];
  hctlp_pkg::key_t tbl_key   [DEPTH];
  logic [31:0]     tbl_count [DEPTH];
  int              tbl_used;

  reply_t          pending_replies [$];
  hctlp_pkg::key_t key_pool [POOL];
  bit     failed;
  bit     idle_en;
  int     cycles;
  int     stall_left;

  hash_count_table_linear_probe i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] xorshift(logic [63:0] h);
    return h ^ (h << hctlp_pkg::SHIFT_LEFT) ^ (h >> hctlp_pkg::SHIFT_RIGHT);
  endfunction

  function automatic logic [63:0] keep_bytes(logic [63:0] v, int n);
    if (n >= 8) return v;
    return v & ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  // clamp length and zero the unused bytes
  function automatic hctlp_pkg::key_t canon(hctlp_pkg::key_t k);
    hctlp_pkg::key_t c;
    int   n;
    c = k;
    n = (k.key_bytes > MAX_BYTES) ? MAX_BYTES : int'(k.key_bytes);
    c.key_bytes  = 5'(n);
    c.value_low  = keep_bytes(k.value_low, n);
    c.value_high = (n > 8) ? keep_bytes(k.value_high, n - 8) : 64'd0;
    return c;
  endfunction

  function automatic logic [31:0] key_digest(hctlp_pkg::key_t k);
    logic [63:0] h;
    logic [63:0] w;
    h = xorshift(64'(k.reg_id));
    h = xorshift(h ^ 64'(k.key_kind));
    h = xorshift(h ^ 64'(k.key_bytes));
    for (int i = 0; i < int'(k.key_bytes); i++) begin
      w = (i < 8) ? k.value_low : k.value_high;
      h = xorshift(h ^ ((w >> (8 * (i % 8))) & 64'hff));
    end
    return h[31:0] ^ h[63:hctlp_pkg::FOLD];
  endfunction

  function automatic reply_t table_access(logic op, hctlp_pkg::key_t raw, logic [31:0] init);
    reply_t r;
    hctlp_pkg::key_t k;
    logic [31:0] h;
    int     idx;
    k = canon(raw);
    h = key_digest(k);
    idx = int'(h % DEPTH);
    r.status = (op == hctlp_pkg::OP_INSERT) ? hctlp_pkg::ST_FULL : hctlp_pkg::ST_NOT_FOUND;
    r.hit_count = 32'd0;
    r.slot = 10'(idx);
    for (int n = 0; n < DEPTH; n++) begin
      if (!tbl_valid[idx]) begin
        r.slot = 10'(idx);
        if (op == hctlp_pkg::OP_INSERT) begin
          tbl_valid[idx] = 1'b1;
          tbl_hash[idx]  = h;
          tbl_key[idx]   = k;
          tbl_count[idx] = init;
          tbl_used++;
          r.status = hctlp_pkg::ST_INSERTED;
          r.hit_count = init;
        end
        break;
      end
      if (tbl_hash[idx] == h && tbl_key[idx] == k) begin
        r.slot = 10'(idx);
        if (op == hctlp_pkg::OP_INSERT) begin
          if (tbl_count[idx] != '1) tbl_count[idx]++;
          r.status = hctlp_pkg::ST_INCREMENTED;
        end else begin
          r.status = hctlp_pkg::ST_FOUND;
        end
        r.hit_count = tbl_count[idx];
        break;
      end
      idx = (idx + 1) % DEPTH;
    end
    r.occupancy = 11'(tbl_used);
    return r;
  endfunction

  function automatic hctlp_pkg::key_t random_key();
    hctlp_pkg::key_t k;
    k.reg_id      = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
    k.key_kind    = 16'($urandom);
    k.key_bytes   = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                                : 5'($urandom_range(0, 16));
    k.value_low   = {$urandom, $urandom};
    k.value_high  = {$urandom, $urandom};
    return k;
  endfunction

  task automatic send_word(logic op, hctlp_pkg::key_t k, logic [31:0] init, bit typed,
                           logic [2:0] t_status, logic [31:0] t_count);
    reply_t r;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 9)) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b0, init, k.value_high, k.value_low, k.key_bytes, k.key_kind,
                 k.reg_id};
    do @(posedge clk); while (!s_tready);
    r = table_access(op, k, init);
    if (typed) begin
      r.status = t_status;
      r.hit_count = t_count;
    end
    pending_replies.push_back(r);
  endtask

  task automatic drain();
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = reply_t'(m_tdata);
      if (pending_replies.size() == 0) begin
        $error("unexpected result word %h", m_tdata);
        failed = 1'b1;
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          failed = 1'b1;
        end
        if (got.hit_count !== want.hit_count) begin
          $error("hit_count: expected %h, got %h", want.hit_count, got.hit_count);
          failed = 1'b1;
        end
        if (got.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, got.slot);
          failed = 1'b1;
        end
        if (got.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    hctlp_pkg::key_t k;
    int   guard;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    failed = 1'b0;
    idle_en = 1'b1;
    cycles = 0;
    stall_left = 0;
    tbl_used = 0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (ROWS[i])
      send_word(ROWS[i].op, ROWS[i].key, ROWS[i].init, ROWS[i].typed,
                ROWS[i].status, ROWS[i].hit_count);
    @(negedge clk);
    s_tvalid <= 1'b0;
    drain();

    foreach (key_pool[i]) key_pool[i] = random_key();
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 2) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        drain();
      end
      k = ($urandom_range(0, 9) == 0) ? random_key() : key_pool[$urandom_range(0, POOL - 1)];
      if ($urandom_range(0, 3) == 0) begin
        k.value_low  = k.value_low ^ {$urandom, $urandom};
        k.value_high = k.value_high ^ {$urandom, $urandom};
      end
      send_word(1'($urandom_range(0, 1)), k,
                ($urandom_range(0, 9) == 0) ? 32'hffff_fffe : $urandom, 1'b0, '0, '0);
    end

    // fill to capacity, then probe the full table
    guard = 0;
    while (tbl_used < DEPTH && guard < 4 * DEPTH) begin
      if (tbl_used >= DEPTH - 100) idle_en = 1'b0;
      send_word(hctlp_pkg::OP_INSERT, random_key(), $urandom, 1'b0, '0, '0);
      guard++;
    end
    idle_en = 1'b0;
    for (int n = 0; n < 6; n++) begin
      send_word(hctlp_pkg::OP_INSERT, random_key(), $urandom, 1'b0, '0, '0);
      send_word(hctlp_pkg::OP_LOOKUP, random_key(), $urandom, 1'b0, '0, '0);
    end
    send_word(hctlp_pkg::OP_INSERT, key_pool[0], $urandom, 1'b0, '0, '0);
    send_word(hctlp_pkg::OP_LOOKUP, key_pool[1], $urandom, 1'b0, '0, '0);
    @(negedge clk);
    s_tvalid <= 1'b0;
    drain();
    repeat (50) @(posedge clk);
    if (failed) begin
      $display("TEST FAILED");
    end else begin
      $display("TEST PASSED");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+design
design/hctlp_pkg.sv
design/hctlp_hash.sv
design/hash_count_table_linear_probe.sv
design/hctlp_checker.sv
bench/testbench.sv
